FILE: hdl/spte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spte_pkg: shared types and constants of the sparse polynomial term engine
// Action and status codes, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package spte_pkg;

  localparam int MAX_TERMS    = 64;
  localparam int MAX_EXPONENT = 63;
  localparam int FRAC_BITS    = 16;

  localparam int ADDR_W  = $clog2(MAX_TERMS);
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);
  localparam int EXP_W   = 6;
  localparam int COEF_W  = 32;
  localparam int POINT_W = 16;
  localparam int VALUE_W = 64;
  localparam int PART_W  = COEF_W + POINT_W;
  localparam int PROD_W  = VALUE_W + POINT_W;

  typedef enum logic [2:0] {
    ACT_ADD_TERM = 3'd0,
    ACT_SET_COEF = 3'd1,
    ACT_ADD_COEF = 3'd2,
    ACT_GET_COEF = 3'd3,
    ACT_EVALUATE = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_COEF = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_NEXT,
    S_READ,
    S_CHECK,
    S_POW,
    S_POW_LO,
    S_POW_HI,
    S_POW_FIX,
    S_ACCUM,
    S_TAIL,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic check;
    logic inc;
    logic pow_lo;
    logic pow_hi;
    logic pow_fix;
    logic accum;
    logic tail;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    action_t act;
    logic    scan_end;
    logic    hit;
    logic    k_zero;
  } dp_stat_t;

endpackage

FILE: hdl/spte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spte_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/spte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spte_ctrl: controller of the term engine
// Sequences the table scan, the power steps and the result strobe.
// ----------------------------------------------------------------------------
module spte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  spte_pkg::dp_stat_t stat,
  output spte_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);

  spte_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spte_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      spte_pkg::S_IDLE: begin
        if (start) state_next = spte_pkg::S_DECODE;
      end
      spte_pkg::S_DECODE: begin
        unique case (stat.act) inside
          spte_pkg::ACT_SET_COEF, spte_pkg::ACT_ADD_COEF, spte_pkg::ACT_GET_COEF,
          spte_pkg::ACT_EVALUATE, spte_pkg::ACT_CLEAR: state_next = spte_pkg::S_NEXT;
          default: state_next = spte_pkg::S_TAIL;
        endcase
      end
      spte_pkg::S_NEXT: begin
        state_next = stat.scan_end ? spte_pkg::S_TAIL : spte_pkg::S_READ;
      end
      spte_pkg::S_READ: state_next = spte_pkg::S_CHECK;
      spte_pkg::S_CHECK: begin
        if (stat.act == spte_pkg::ACT_EVALUATE) begin
          state_next = spte_pkg::S_POW;
        end else if (stat.act == spte_pkg::ACT_GET_COEF && stat.hit) begin
          state_next = spte_pkg::S_TAIL;
        end else begin
          state_next = spte_pkg::S_NEXT;
        end
      end
      spte_pkg::S_POW: begin
        state_next = stat.k_zero ? spte_pkg::S_ACCUM : spte_pkg::S_POW_LO;
      end
      spte_pkg::S_POW_LO:  state_next = spte_pkg::S_POW_HI;
      spte_pkg::S_POW_HI:  state_next = spte_pkg::S_POW_FIX;
      spte_pkg::S_POW_FIX: state_next = spte_pkg::S_POW;
      spte_pkg::S_ACCUM:   state_next = spte_pkg::S_NEXT;
      spte_pkg::S_TAIL:    state_next = spte_pkg::S_DONE;
      spte_pkg::S_DONE:    state_next = spte_pkg::S_IDLE;
      default:             state_next = spte_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd     = '0;
    busy    = (state != spte_pkg::S_IDLE);
    done    = (state == spte_pkg::S_DONE);
    unique case (state)
      spte_pkg::S_IDLE:    cmd.latch   = start;
      spte_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        cmd.inc   = (stat.act != spte_pkg::ACT_EVALUATE) &&
                    !(stat.act == spte_pkg::ACT_GET_COEF && stat.hit);
      end
      spte_pkg::S_POW_LO:  cmd.pow_lo  = 1'b1;
      spte_pkg::S_POW_HI:  cmd.pow_hi  = 1'b1;
      spte_pkg::S_POW_FIX: cmd.pow_fix = 1'b1;
      spte_pkg::S_ACCUM: begin
        cmd.accum = 1'b1;
        cmd.inc   = 1'b1;
      end
      spte_pkg::S_TAIL:    cmd.tail    = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: hdl/spte_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spte_dp: datapath of the term engine
// Term tables, scan index, power multiplier and saturating accumulator.
// ----------------------------------------------------------------------------
module spte_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  spte_pkg::cmd_t                   cmd,
  input  logic [2:0]                       action,
  input  logic signed [spte_pkg::COEF_W-1:0]  coefficient,
  input  logic [spte_pkg::EXP_W-1:0]       exponent,
  input  logic signed [spte_pkg::POINT_W-1:0] point,
  output spte_pkg::dp_stat_t               stat,
  output logic [1:0]                       status,
  output logic signed [spte_pkg::VALUE_W-1:0] value,
  output logic [spte_pkg::CNT_W-1:0]       term_total
);

  localparam logic [spte_pkg::VALUE_W-1:0] MAXPOS = {1'b0, {(spte_pkg::VALUE_W-1){1'b1}}};
  localparam logic [spte_pkg::VALUE_W-1:0] MINNEG = {1'b1, {(spte_pkg::VALUE_W-1){1'b0}}};

  // request registers
  logic [2:0]                   act;
  logic [spte_pkg::COEF_W-1:0]  c;
  logic [spte_pkg::EXP_W-1:0]   e;
  logic [spte_pkg::POINT_W-1:0] ux;
  logic                         xneg;

  // scan and term state
  logic [spte_pkg::CNT_W-1:0]   idx;
  logic [spte_pkg::CNT_W-1:0]   count;
  logic                         found;
  logic [spte_pkg::VALUE_W-1:0] ta;
  logic                         tneg;
  logic [spte_pkg::EXP_W-1:0]   k;
  logic [spte_pkg::PART_W-1:0]  plo;
  logic [spte_pkg::PART_W-1:0]  phi;
  logic [spte_pkg::VALUE_W-1:0] acc;
  logic [1:0]                   res_status;
  logic [spte_pkg::VALUE_W-1:0] res_value;

  // table ports
  logic                         coef_we;
  logic [spte_pkg::ADDR_W-1:0]  coef_waddr;
  logic [spte_pkg::COEF_W-1:0]  coef_wdata;
  logic [spte_pkg::COEF_W-1:0]  rcoef;
  logic                         exp_we;
  logic [spte_pkg::EXP_W-1:0]   rexp;

  logic                         hit;
  logic                         full;
  logic                         append;
  logic [spte_pkg::COEF_W:0]    sum33;
  logic [spte_pkg::COEF_W-1:0]  sat32;
  logic [spte_pkg::PROD_W-1:0]  prod;
  logic                         pneg;
  logic [spte_pkg::VALUE_W-1:0] plim;
  logic [spte_pkg::VALUE_W-1:0] tval;
  logic [spte_pkg::VALUE_W-1:0] asum;
  logic [spte_pkg::VALUE_W-1:0] asat;

  spte_ram #(.WIDTH(spte_pkg::COEF_W), .DEPTH(spte_pkg::MAX_TERMS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (idx[spte_pkg::ADDR_W-1:0]),
    .rdata (rcoef)
  );

  spte_ram #(.WIDTH(spte_pkg::EXP_W), .DEPTH(spte_pkg::MAX_TERMS)) u_exp (
    .clk   (clk),
    .we    (exp_we),
    .waddr (count[spte_pkg::ADDR_W-1:0]),
    .wdata (e),
    .raddr (idx[spte_pkg::ADDR_W-1:0]),
    .rdata (rexp)
  );

  // match, full and saturating coefficient add
  assign hit   = (rexp == e);
  assign full  = (count >= spte_pkg::CNT_W'(spte_pkg::MAX_TERMS));
  assign sum33 = {rcoef[spte_pkg::COEF_W-1], rcoef} + {c[spte_pkg::COEF_W-1], c};
  always_comb begin
    if (sum33[spte_pkg::COEF_W] != sum33[spte_pkg::COEF_W-1]) begin
      sat32 = sum33[spte_pkg::COEF_W] ? {1'b1, {(spte_pkg::COEF_W-1){1'b0}}}
                                      : {1'b0, {(spte_pkg::COEF_W-1){1'b1}}};
    end else begin
      sat32 = sum33[spte_pkg::COEF_W-1:0];
    end
  end

  // append decision at the end of a request
  always_comb begin
    append = 1'b0;
    if (act == spte_pkg::ACT_ADD_TERM) begin
      append = (c != '0) && !full;
    end else if (act == spte_pkg::ACT_SET_COEF) begin
      append = !found && !full;
    end
  end

  // table write port
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = idx[spte_pkg::ADDR_W-1:0];
    coef_wdata = c;
    exp_we     = 1'b0;
    if (cmd.check) begin
      case (act)
        spte_pkg::ACT_SET_COEF: coef_we = hit;
        spte_pkg::ACT_ADD_COEF: begin
          coef_we    = hit;
          coef_wdata = sat32;
        end
        spte_pkg::ACT_CLEAR: begin
          coef_we    = 1'b1;
          coef_wdata = '0;
        end
        default: ;
      endcase
    end else if (cmd.tail && append) begin
      coef_we    = 1'b1;
      coef_waddr = count[spte_pkg::ADDR_W-1:0];
      exp_we     = 1'b1;
    end
  end

  // power step: magnitude product and saturation
  assign prod = {phi, {(spte_pkg::PROD_W-spte_pkg::PART_W){1'b0}}} +
                {{(spte_pkg::PROD_W-spte_pkg::PART_W){1'b0}}, plo};
  assign pneg = tneg ^ xneg;
  assign plim = pneg ? MINNEG : MAXPOS;

  // signed term and saturating accumulate
  assign tval = tneg ? (~ta + 1'b1) : ta;
  assign asum = acc + tval;
  always_comb begin
    if ((acc[spte_pkg::VALUE_W-1] == tval[spte_pkg::VALUE_W-1]) &&
        (asum[spte_pkg::VALUE_W-1] != acc[spte_pkg::VALUE_W-1])) begin
      asat = acc[spte_pkg::VALUE_W-1] ? MINNEG : MAXPOS;
    end else begin
      asat = asum;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.latch) begin
        idx   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.inc) idx <= idx + 1'b1;
        if (cmd.check && hit) found <= 1'b1;
      end
      if (cmd.tail && append) count <= count + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act       <= action;
      c         <= coefficient;
      e         <= (exponent > spte_pkg::EXP_W'(spte_pkg::MAX_EXPONENT))
                   ? spte_pkg::EXP_W'(spte_pkg::MAX_EXPONENT) : exponent;
      xneg      <= point[spte_pkg::POINT_W-1];
      ux        <= point[spte_pkg::POINT_W-1] ? (~point + 1'b1) : point;
      acc       <= '0;
      res_value <= '0;
    end
    if (cmd.check) begin
      tneg <= rcoef[spte_pkg::COEF_W-1];
      ta   <= {{(spte_pkg::VALUE_W-spte_pkg::COEF_W){1'b0}},
               (rcoef[spte_pkg::COEF_W-1] ? (~rcoef + 1'b1) : rcoef)};
      k    <= rexp;
      if (act == spte_pkg::ACT_GET_COEF && hit && !found) begin
        res_value <= {{(spte_pkg::VALUE_W-spte_pkg::COEF_W){rcoef[spte_pkg::COEF_W-1]}},
                      rcoef};
      end
    end
    if (cmd.pow_lo) plo <= ta[spte_pkg::COEF_W-1:0] * ux;
    if (cmd.pow_hi) phi <= ta[spte_pkg::VALUE_W-1:spte_pkg::COEF_W] * ux;
    if (cmd.pow_fix) begin
      k    <= k - 1'b1;
      tneg <= pneg;
      if (prod > {{(spte_pkg::PROD_W-spte_pkg::VALUE_W){1'b0}}, plim}) begin
        ta <= plim;
      end else begin
        ta <= prod[spte_pkg::VALUE_W-1:0];
      end
    end
    if (cmd.accum) acc <= asat;
    if (cmd.tail) begin
      case (act) inside
        spte_pkg::ACT_ADD_TERM: begin
          if (c == '0) res_status <= spte_pkg::ST_ZERO_COEF;
          else if (full) res_status <= spte_pkg::ST_FULL;
          else res_status <= spte_pkg::ST_OK;
        end
        spte_pkg::ACT_SET_COEF: begin
          res_status <= (!found && full) ? spte_pkg::ST_FULL : spte_pkg::ST_OK;
        end
        spte_pkg::ACT_ADD_COEF, spte_pkg::ACT_GET_COEF: begin
          res_status <= found ? spte_pkg::ST_OK : spte_pkg::ST_NOT_FOUND;
        end
        spte_pkg::ACT_EVALUATE: begin
          res_status <= spte_pkg::ST_OK;
          res_value  <= acc;
        end
        default: res_status <= spte_pkg::ST_OK;
      endcase
    end
  end

  // status to controller and result ports
  assign stat.act      = spte_pkg::action_t'(act);
  assign stat.scan_end = (idx == count);
  assign stat.hit      = hit;
  assign stat.k_zero   = (k == '0);
  assign status        = res_status;
  assign value         = res_value;
  assign term_total    = count;

endmodule

FILE: hdl/sparse_polynomial_term_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_term_engine_core: sparse polynomial term engine
// Term table with add, set, add-to, get, evaluate and clear requests.
// ----------------------------------------------------------------------------
// add_term and unused codes skip the table scan; set/add-to/clear scan every
//   stored term, get the same but stops after the first match; evaluate
//   scans every term and multiplies it by the point once per exponent unit,
//   a 64x16 power step split into two 32x16 partial products
// one request at a time; busy is high from acceptance through the done cycle
// done strobes the result for one cycle; the receiver cannot stall
// reset clears the controller and the term count; the tables need no clearing
module sparse_polynomial_term_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          action,
  input  logic signed [spte_pkg::COEF_W-1:0]  coefficient,
  input  logic [spte_pkg::EXP_W-1:0]          exponent,
  input  logic signed [spte_pkg::POINT_W-1:0] point,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [spte_pkg::VALUE_W-1:0] value,
  output logic [spte_pkg::CNT_W-1:0]          term_total
);

  spte_pkg::cmd_t     cmd;
  spte_pkg::dp_stat_t stat;

  spte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  spte_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .coefficient (coefficient),
    .exponent    (exponent),
    .point       (point),
    .stat        (stat),
    .status      (status),
    .value       (value),
    .term_total  (term_total)
  );

endmodule
